@@ rtl/rth_pkg.sv @@
// Shared types and constants for the RGB to centered HSI pixel converter.
package rth_pkg;

	localparam int PIX_W      = 8;
	localparam int Q_W        = 16;
	localparam int CENTER_W   = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// Divider geometry: numerator, divisor and quotient widths, two lanes
	localparam int DIV_NUM_W = 35;
	localparam int DIV_DEN_W = 21;
	localparam int DIV_QUO_W = 15;
	localparam int DIV_LANES = 2;
	localparam int LANE_SAT  = 0;
	localparam int LANE_HUE  = 1;

	// Q2.13 one
	localparam logic [Q_W-1:0] Q_ONE = 16'd8192;

	// Reciprocals for exact division by the constants 510 and 1530
	localparam logic [23:0] PLAIN_RECIP = 24'd8421505;
	localparam logic [25:0] INT_RECIP   = 26'd44914691;
	// 2 * 16384 * 3000, scaled saturation numerator per unit of the minimum
	localparam logic [26:0] SAT_SCALE   = 27'd98304000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 2'd0,
		REG_HUE_CENTER = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic signed [Q_W-1:0] hue_or_first;
		logic signed [Q_W-1:0] sat_or_second;
		logic signed [Q_W-1:0] int_or_third;
	} result_t;

	// Values that ride alongside the divider
	typedef struct packed {
		logic                  mode;
		logic signed [Q_W-1:0] plain_r;
		logic signed [Q_W-1:0] plain_g;
		logic signed [Q_W-1:0] plain_b;
		logic signed [Q_W-1:0] inten;
	} aux_t;

	typedef logic [DIV_LANES-1:0][DIV_NUM_W-1:0] div_num_t;
	typedef logic [DIV_LANES-1:0][DIV_DEN_W-1:0] div_den_t;
	typedef logic [DIV_LANES-1:0][DIV_QUO_W-1:0] div_quo_t;

endpackage

@@ rtl/rth_front.sv @@
// Front pipeline: pixel features, hue sector, divider operands and constant divisions.
module rth_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  rth_pkg::pixel_t pixel,
	input  logic            mode,
	output logic            out_valid,
	output rth_pkg::div_num_t num,
	output rth_pkg::div_den_t den,
	output rth_pkg::aux_t   aux
);

	// stage 1: captured pixel
	logic            valid_s1;
	logic            mode_s1;
	rth_pkg::pixel_t pix_s1;

	// stage 2: sum, min, sector, plain products
	logic                valid_s2;
	logic                mode_s2;
	logic [9:0]          sum_s2;
	logic [7:0]          min_s2;
	rth_pkg::sector_t    sec_s2;
	logic signed [8:0]   diff_s2;
	logic [7:0]          delta_s2;
	logic [2:0][46:0]    prod_s2;

	// stage 3: sector divisor, saturation operands, intensity product
	logic                valid_s3;
	logic                mode_s3;
	logic [17:0]         d_s3;
	logic signed [8:0]   diff_s3;
	rth_pkg::sector_t    sec_s3;
	logic [34:0]         sat_num_s3;
	logic [20:0]         sat_den_s3;
	logic [50:0]         iprod_s3;
	logic [2:0][15:0]    plain_s3;

	logic [9:0]          sum2;
	logic [7:0]          min2;
	rth_pkg::sector_t    sec2;
	logic signed [8:0]   diff2;
	logic [7:0]          delta2;
	logic [2:0][46:0]    prod2;

	logic [17:0]         d3;
	logic [20:0]         sat_den3;
	logic [34:0]         sat_num3;
	logic [50:0]         iprod3;
	logic [2:0][15:0]    plain3;

	logic signed [22:0]  n_diff4;
	logic signed [22:0]  off4;
	logic signed [22:0]  n_raw4;
	logic signed [22:0]  n_wrap4;
	logic [20:0]         d6_4;
	logic [19:0]         d3x4;
	logic [34:0]         hue_num4;
	logic [15:0]         inten4;

	// capture input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1  <= pixel;
		mode_s1 <= mode;
	end

	// sum, minimum and sector selection
	always_comb begin
		sum2 = 10'(pix_s1.red) + 10'(pix_s1.green) + 10'(pix_s1.blue);
		min2 = (pix_s1.red < pix_s1.green) ? pix_s1.red : pix_s1.green;
		if (pix_s1.blue < min2) begin
			min2 = pix_s1.blue;
		end
		if (pix_s1.red > pix_s1.green && pix_s1.red > pix_s1.blue) begin
			sec2   = rth_pkg::SEC_RED;
			diff2  = $signed({1'b0, pix_s1.green}) - $signed({1'b0, pix_s1.blue});
			delta2 = pix_s1.red - min2;
		end else if (pix_s1.red <= pix_s1.green && pix_s1.green > pix_s1.blue) begin
			sec2   = rth_pkg::SEC_GREEN;
			diff2  = $signed({1'b0, pix_s1.blue}) - $signed({1'b0, pix_s1.red});
			delta2 = pix_s1.green - min2;
		end else begin
			sec2   = rth_pkg::SEC_BLUE;
			diff2  = $signed({1'b0, pix_s1.red}) - $signed({1'b0, pix_s1.green});
			delta2 = pix_s1.blue - min2;
		end
		// plain scaling: floor((32768x + 255) / 510) by reciprocal
		prod2[0] = 47'({pix_s1.red,   15'd255}) * 47'(rth_pkg::PLAIN_RECIP);
		prod2[1] = 47'({pix_s1.green, 15'd255}) * 47'(rth_pkg::PLAIN_RECIP);
		prod2[2] = 47'({pix_s1.blue,  15'd255}) * 47'(rth_pkg::PLAIN_RECIP);
	end

	always_ff @(posedge clk) begin
		mode_s2  <= mode_s1;
		sum_s2   <= sum2;
		min_s2   <= min2;
		sec_s2   <= sec2;
		diff_s2  <= diff2;
		delta_s2 <= delta2;
		prod_s2  <= prod2;
	end

	// sector divisor, saturation operands, intensity product
	always_comb begin
		d3       = 18'(delta_s2) * 18'd1000 + 18'd255;
		sat_den3 = 21'(sum_s2) * 21'd2000 + 21'd1530;
		// add half the divisor so the quotient rounds half up
		sat_num3 = 35'(min_s2) * 35'(rth_pkg::SAT_SCALE) + 35'(sat_den3[20:1]);
		iprod3   = 51'({sum_s2, 15'd765}) * 51'(rth_pkg::INT_RECIP);
		for (int i = 0; i < 3; i++) begin
			plain3[i] = 16'(prod_s2[i][46:32]) - rth_pkg::Q_ONE;
		end
	end

	always_ff @(posedge clk) begin
		mode_s3    <= mode_s2;
		d_s3       <= d3;
		diff_s3    <= diff_s2;
		sec_s3     <= sec_s2;
		sat_num_s3 <= sat_num3;
		sat_den_s3 <= sat_den3;
		iprod_s3   <= iprod3;
		plain_s3   <= plain3;
	end

	// hue numerator with wrap into 0..6, intensity
	always_comb begin
		n_diff4 = 23'(diff_s3) * 23'sd1000;
		case (sec_s3)
			rth_pkg::SEC_GREEN: off4 = 23'({d_s3, 1'b0});
			rth_pkg::SEC_BLUE:  off4 = 23'({d_s3, 2'b0});
			default:            off4 = '0;
		endcase
		d6_4   = 21'({d_s3, 2'b0}) + 21'({d_s3, 1'b0});
		d3x4   = 20'({d_s3, 1'b0}) + 20'(d_s3);
		n_raw4 = n_diff4 + off4;
		if (n_raw4 < 0) begin
			n_wrap4 = n_raw4 + $signed(23'(d6_4));
		end else begin
			n_wrap4 = n_raw4;
		end
		hue_num4 = {n_wrap4[20:0], 14'd0} + 35'(d3x4);
		inten4   = 16'(iprod_s3[50:36]) - rth_pkg::Q_ONE;
	end

	always_ff @(posedge clk) begin
		num[rth_pkg::LANE_SAT] <= sat_num_s3;
		den[rth_pkg::LANE_SAT] <= sat_den_s3;
		num[rth_pkg::LANE_HUE] <= hue_num4;
		den[rth_pkg::LANE_HUE] <= d6_4;
		aux.mode    <= mode_s3;
		aux.plain_r <= $signed(plain_s3[0]);
		aux.plain_g <= $signed(plain_s3[1]);
		aux.plain_b <= $signed(plain_s3[2]);
		aux.inten   <= $signed(inten4);
	end

endmodule

@@ rtl/rth_div.sv @@
// Pipelined two-lane restoring divider, one quotient bit per stage.
module rth_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rth_pkg::div_num_t num,
	input  rth_pkg::div_den_t den,
	input  rth_pkg::aux_t     aux_in,
	output logic              out_valid,
	output rth_pkg::div_quo_t quo,
	output rth_pkg::aux_t     aux_out
);

	localparam int QW = rth_pkg::DIV_QUO_W;
	localparam int NW = rth_pkg::DIV_NUM_W;
	localparam int L  = rth_pkg::DIV_LANES;

	logic              val_s [QW+1];
	rth_pkg::div_quo_t quo_s [QW+1];
	rth_pkg::aux_t     aux_s [QW+1];
	rth_pkg::div_num_t rem_s [QW];
	rth_pkg::div_den_t den_s [QW];

	assign val_s[0] = in_valid;
	assign quo_s[0] = '0;
	assign aux_s[0] = aux_in;
	assign rem_s[0] = num;
	assign den_s[0] = den;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int SH = QW - 1 - k;
		rth_pkg::div_num_t sub;
		rth_pkg::div_quo_t qn;
		logic [L-1:0]      ge;

		// trial subtract of the shifted divisor
		always_comb begin
			for (int l = 0; l < L; l++) begin
				ge[l]  = rem_s[k][l] >= (NW'(den_s[k][l]) << SH);
				sub[l] = ge[l] ? rem_s[k][l] - (NW'(den_s[k][l]) << SH) : rem_s[k][l];
				qn[l]  = quo_s[k][l] | (QW'(ge[l]) << SH);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k+1] <= 1'b0;
			end else begin
				val_s[k+1] <= val_s[k];
			end
		end

		always_ff @(posedge clk) begin
			quo_s[k+1] <= qn;
			aux_s[k+1] <= aux_s[k];
		end

		// remainder and divisor only go on while bits remain
		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= sub;
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign out_valid = val_s[QW];
	assign quo       = quo_s[QW];
	assign aux_out   = aux_s[QW];

endmodule

@@ rtl/rgb_to_centered_hsi_pixel.sv @@
// Top level of the RGB to centered HSI pixel converter.
//
// Usage:
//   Pixel beats enter on start with pixel (red, green, blue bytes); busy stays
//   low, so a new beat is taken in every cycle.
//   Each result beat shows on result for one cycle with done high: hue,
//   saturation and intensity in Q2.13 (mode 0), or each channel scaled to
//   x/127.5 - 1 (mode 1). The receiver cannot stall; results must be taken.
//   Pipeline: each pixel passes four front stages, fifteen divider stages
//   and one output register before its result beat shows with done high.
//   Throughput: one pixel per cycle, set by the fully pipelined two-lane
//   divider that forms saturation and hue one quotient bit per stage.
//   Configuration: cfg_index/cfg_data on a valid/ready write port, always
//   ready; index 0 is mode, index 1 is the 15-bit signed hue center. Write
//   only while no pixel is in flight.
//   Reset: arst_n clears all valid bits and the registers (mode 0, center 0);
//   pixels in flight are dropped.
module rgb_to_centered_hsi_pixel (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  rth_pkg::pixel_t                   pixel,
	output logic                              done,
	output rth_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rth_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rth_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic                                mode_q;
	logic signed [rth_pkg::CENTER_W-1:0] hue_center_q;

	logic              fr_valid;
	rth_pkg::div_num_t fr_num;
	rth_pkg::div_den_t fr_den;
	rth_pkg::aux_t     fr_aux;

	logic              dv_valid;
	rth_pkg::div_quo_t dv_quo;
	rth_pkg::aux_t     dv_aux;

	logic signed [17:0] hc;
	logic signed [17:0] hue_w;
	logic [15:0]        sat_w;
	rth_pkg::result_t   res_d;

	logic             done_q;
	logic             res_mode_q;
	rth_pkg::result_t res_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			hue_center_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rth_pkg::REG_MODE) begin
				mode_q <= cfg_data[0];
			end else if (cfg_index == rth_pkg::REG_HUE_CENTER) begin
				hue_center_q <= $signed(cfg_data);
			end
		end
	end

	rth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.pixel     (pixel),
		.mode      (mode_q),
		.out_valid (fr_valid),
		.num       (fr_num),
		.den       (fr_den),
		.aux       (fr_aux)
	);

	rth_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.num       (fr_num),
		.den       (fr_den),
		.aux_in    (fr_aux),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.aux_out   (dv_aux)
	);

	// center the hue, finish saturation, select by mode
	always_comb begin
		hc = $signed(18'(dv_quo[rth_pkg::LANE_HUE]) - 18'(rth_pkg::Q_ONE))
			- 18'(hue_center_q);
		if (hc < -18'sd8192) begin
			hue_w = hc + 18'sd16384;
		end else begin
			hue_w = hc;
		end
		sat_w = rth_pkg::Q_ONE - 16'(dv_quo[rth_pkg::LANE_SAT]);
		if (dv_aux.mode) begin
			res_d.hue_or_first  = dv_aux.plain_r;
			res_d.sat_or_second = dv_aux.plain_g;
			res_d.int_or_third  = dv_aux.plain_b;
		end else begin
			res_d.hue_or_first  = 16'(hue_w);
			res_d.sat_or_second = $signed(sat_w);
			res_d.int_or_third  = dv_aux.inten;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q      <= res_d;
		res_mode_q <= dv_aux.mode;
	end

	assign done   = done_q;
	assign result = res_q;

	// every result beat traces back to an earlier accepted pixel beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 20))
		else $error("result without matching pixel beat");

	// HSI saturation stays within -1..1
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res_mode_q) |->
		(result.sat_or_second >= -16'sd8192 && result.sat_or_second <= 16'sd8192))
		else $error("saturation out of range");

	// HSI intensity stays within -1..1
	a_int_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res_mode_q) |->
		(result.int_or_third >= -16'sd8192 && result.int_or_third <= 16'sd8192))
		else $error("intensity out of range");

endmodule

@@ test/rgb_to_centered_hsi_pixel_test.sv @@
// Self-checking testbench for the RGB to centered HSI pixel converter.
`timescale 1ns / 1ps

module rgb_to_centered_hsi_pixel_test;

	localparam logic [rth_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASE_PIXELS = 200;
	localparam int NUM_PHASES = 7;

	typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [rth_pkg::CFG_IDX_W-1:0]   index;
		logic [rth_pkg::CFG_DATA_W-1:0]  data;
		rth_pkg::pixel_t                 pix;
		bit                              has_exp;
		rth_pkg::result_t                exp;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	rth_pkg::pixel_t pixel;
	logic done;
	rth_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [rth_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rth_pkg::CFG_DATA_W-1:0] cfg_data;

	// Local copy of the configuration
	bit mode_plain;
	logic signed [rth_pkg::CENTER_W-1:0] center;

	rth_pkg::result_t expected_q[$];
	int mismatches;
	int results_seen;
	int pixels_sent;
	int cfg_writes;
	bit idle_enable;

	rgb_to_centered_hsi_pixel dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// floor(num/den + 1/2) for nonnegative operands
	function automatic longint round_div(longint num, longint den);
		return (2 * num + den) / (2 * den);
	endfunction

	// Compute the converted pixel under the current configuration
	function automatic rth_pkg::result_t convert_pixel(rth_pkg::pixel_t p);
		longint r, g, b, s, m, diff, delta, off, d, n, hue, hc;
		rth_pkg::result_t res;
		r = p.red;
		g = p.green;
		b = p.blue;
		if (mode_plain) begin
			res.hue_or_first  = 16'(round_div(16384 * r, 255) - 8192);
			res.sat_or_second = 16'(round_div(16384 * g, 255) - 8192);
			res.int_or_third  = 16'(round_div(16384 * b, 255) - 8192);
			return res;
		end
		s = r + g + b;
		m = (r < g) ? r : g;
		if (b < m)
			m = b;
		res.int_or_third  = 16'(round_div(16384 * s, 765) - 8192);
		res.sat_or_second = 16'(8192 - round_div(longint'(16384) * 3000 * m, 1000 * s + 765));
		if (r > g && r > b) begin
			diff = g - b;
			delta = r - m;
			off = 0;
		end else if (r <= g && g > b) begin
			diff = b - r;
			delta = g - m;
			off = 2;
		end else begin
			diff = r - g;
			delta = b - m;
			off = 4;
		end
		d = 1000 * delta + 255;
		n = 1000 * diff + off * d;
		if (n < 0)
			n += 6 * d;
		hue = round_div(8192 * n, 3 * d) - 8192;
		hc = hue - longint'(center);
		if (hc < -8192)
			hc += 16384;
		res.hue_or_first = 16'(hc);
		return res;
	endfunction

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", result);
			end else begin
				rth_pkg::result_t e;
				e = expected_q.pop_front();
				if (result.hue_or_first !== e.hue_or_first
						|| result.sat_or_second !== e.sat_or_second
						|| result.int_or_third !== e.int_or_third) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected h/s/i %0d %0d %0d, got %0d %0d %0d",
							e.hue_or_first, e.sat_or_second, e.int_or_third,
							result.hue_or_first, result.sat_or_second, result.int_or_third);
				end
			end
		end
	end

	// Hold start low for a random burst now and then
	task automatic maybe_idle();
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Send one pixel beat and queue its expected result; pass an expectation to pin it
	task automatic send_pixel(rth_pkg::pixel_t p, bit has_exp, rth_pkg::result_t exp);
		rth_pkg::result_t pred;
		maybe_idle();
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
		pred = convert_pixel(p);
		if (has_exp && pred != exp)
			$display("pinned expectation disagrees with prediction for %p", p);
		expected_q.push_back(has_exp ? exp : pred);
		pixels_sent++;
	endtask

	// Wait out every pixel in flight, then write one register
	task automatic write_reg(logic [rth_pkg::CFG_IDX_W-1:0] idx,
			logic [rth_pkg::CFG_DATA_W-1:0] data);
		start <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == rth_pkg::REG_MODE)
			mode_plain = data[0];
		else if (idx == rth_pkg::REG_HUE_CENTER)
			center = data;
		cfg_writes++;
	endtask

	function automatic stim_row_t pix_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			bit has_exp = 0, logic signed [15:0] h = 0, logic signed [15:0] s = 0,
			logic signed [15:0] i = 0);
		stim_row_t row;
		row.kind = ROW_PIXEL;
		row.index = '0;
		row.data = '0;
		row.pix = '{r, g, b};
		row.has_exp = has_exp;
		row.exp = '{h, s, i};
		return row;
	endfunction

	function automatic stim_row_t cfg_row(logic [rth_pkg::CFG_IDX_W-1:0] idx,
			logic [rth_pkg::CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = pix_row(0, 0, 0);
		row.kind = ROW_CFG;
		row.index = idx;
		row.data = data;
		return row;
	endfunction

	// Random pixel, biased toward ties, gray and extreme channels
	function automatic rth_pkg::pixel_t random_pixel();
		rth_pkg::pixel_t p;
		int sel;
		p = rth_pkg::pixel_t'($urandom);
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				p.green = p.red;
				p.blue = p.red;
			end
			1: p.green = p.red;
			2: p.blue = p.green;
			3: p.blue = p.red;
			4: begin
				p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: ;
		endcase
		return p;
	endfunction

	stim_row_t directed[$];

	initial begin
		start = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		mode_plain = 0;
		center = '0;
		mismatches = 0;
		results_seen = 0;
		pixels_sent = 0;
		cfg_writes = 0;
		idle_enable = 1;

		directed = '{
			pix_row(0, 0, 0, 1, 2731, 8192, -8192),
			pix_row(255, 255, 255),
			pix_row(255, 0, 0),
			pix_row(0, 255, 0),
			pix_row(0, 0, 255),
			pix_row(255, 255, 0),
			pix_row(0, 255, 255),
			pix_row(255, 0, 255),
			pix_row(1, 2, 3),
			pix_row(200, 10, 90),
			cfg_row(rth_pkg::REG_HUE_CENTER, 15'h2000),
			pix_row(255, 0, 0, 1, 0, 8192 - 8192 * 3 * 0 / 1, -2731),
			pix_row(10, 200, 200),
			cfg_row(rth_pkg::REG_HUE_CENTER, 15'h4000),
			pix_row(0, 0, 0, 1, 2731 + 16384, 8192, -8192),
			cfg_row(rth_pkg::REG_HUE_CENTER, 15'h3FFF),
			pix_row(40, 250, 5),
			cfg_row(REG_UNUSED, 15'h7FFF),
			pix_row(90, 90, 90),
			cfg_row(rth_pkg::REG_MODE, 15'h7FFF),
			pix_row(0, 0, 0, 1, -8192, -8192, -8192),
			pix_row(255, 255, 255, 1, 8192, 8192, 8192),
			pix_row(128, 1, 254),
			cfg_row(rth_pkg::REG_MODE, 15'h7FFE),
			pix_row(128, 127, 170)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (directed[k]) begin
			if (directed[k].kind == ROW_CFG)
				write_reg(directed[k].index, directed[k].data);
			else
				send_pixel(directed[k].pix, directed[k].has_exp, directed[k].exp);
		end

		// Random phases across several settings; the last one runs without gaps
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			logic [rth_pkg::CFG_DATA_W-1:0] c;
			case (ph)
				0: c = 15'h0000;
				1: c = 15'h2000;
				2: c = 15'h6000;
				3: c = 15'h4000;
				4: c = 15'h3FFF;
				default: c = rth_pkg::CFG_DATA_W'($urandom);
			endcase
			write_reg(rth_pkg::REG_MODE, (ph == 2 || ph == 5) ? 15'h0001 : 15'h0000);
			write_reg(rth_pkg::REG_HUE_CENTER, c);
			idle_enable = (ph != NUM_PHASES - 1);
			repeat (PHASE_PIXELS)
				send_pixel(random_pixel(), 0, '0);
		end
		start <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d pixels over %0d register writes in both modes", pixels_sent, cfg_writes);
		$display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Give up after a generous fixed time
	initial begin
		#1000000;
		$display("timeout with %0d results outstanding", expected_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
